// ----- rtl/core/khr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// khr_pkg
// Shared types and constants of the key hold and auto-repeat event generator.
// ----------------------------------------------------------------------------
package khr_pkg;

    localparam int MAX_KEYS_DEF = 6;
    localparam int NUM_SLOTS    = 6;
    localparam int NUM_TRACK    = 5;
    localparam int NUM_DIRS     = 4;

    localparam logic [15:0] DELAY_RST  = 16'd500;
    localparam logic [15:0] PERIOD_RST = 16'd100;

    localparam logic [7:0] KEY_UP     = 8'h3B;
    localparam logic [7:0] KEY_DOWN   = 8'h2E;
    localparam logic [7:0] KEY_LEFT   = 8'h2C;
    localparam logic [7:0] KEY_RIGHT  = 8'h2F;
    localparam logic [7:0] KEY_HOME   = 8'h60;
    localparam logic [7:0] KEY_TAB    = 8'h09;
    localparam logic [7:0] KEY_PWR_LO = 8'h70;
    localparam logic [7:0] KEY_PWR_HI = 8'h50;
    localparam logic [7:0] KEY_SETUP  = 8'h73;
    localparam logic [7:0] KEY_ESC    = 8'h1B;

    typedef enum logic [0:0] {
        CFG_DELAY  = 1'b0,
        CFG_PERIOD = 1'b1
    } t_cfg_index;

    typedef enum logic [3:0] {
        EV_CONFIRM = 4'd0,
        EV_REPEAT  = 4'd1,
        EV_NAV     = 4'd2,
        EV_HOME    = 4'd3,
        EV_TOGGLE  = 4'd4,
        EV_POWER   = 4'd5,
        EV_SETUP   = 4'd6,
        EV_ESCAPE  = 4'd7,
        EV_CHAR    = 4'd8
    } t_event_kind;

    typedef enum logic [1:0] {
        DIR_UP    = 2'd0,
        DIR_DOWN  = 2'd1,
        DIR_LEFT  = 2'd2,
        DIR_RIGHT = 2'd3
    } t_nav_dir;

    typedef struct packed {
        logic [31:0] now_ms;
        logic        enter_down;
        logic        shift_down;
        logic        keys_changed;
        logic        any_pressed;
        logic [2:0]  key_count;
        logic [7:0]  key_code_0;
        logic [7:0]  key_code_1;
        logic [7:0]  key_code_2;
        logic [7:0]  key_code_3;
        logic [7:0]  key_code_4;
        logic [7:0]  key_code_5;
    } t_in_item;

    typedef struct packed {
        t_event_kind event_kind;
        logic [1:0]  nav_dir;
        logic [7:0]  char_code;
        logic        shift_out;
    } t_out_item;

    typedef struct packed {
        logic fire;
        logic repeat_hit;
    } t_trk_status;

    typedef struct packed {
        logic [NUM_DIRS-1:0] arrow_now;
        logic                hit;
        t_event_kind         kind;
        logic [7:0]          code;
    } t_key_map;

endpackage

// ----- rtl/core/khr_tracker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// khr_tracker
// Hold tracker for one key: press edge, first repeat after the delay, then
// repeats at the period. State moves only when enabled.
// ----------------------------------------------------------------------------
module khr_tracker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_down,
    input  logic [31:0]          i_now,
    input  logic [15:0]          i_delay,
    input  logic [15:0]          i_period,
    output khr_pkg::t_trk_status o_status
);

    logic        r_held;
    logic        r_rep;
    logic [31:0] r_press;
    logic [31:0] r_last;
    logic        n_held;
    logic        n_rep;
    logic [31:0] n_press;
    logic [31:0] n_last;
    logic [31:0] press_age;
    logic [31:0] last_age;
    logic        fire;

    assign press_age = i_now - r_press;
    assign last_age  = i_now - r_last;

    always_comb begin
        n_held  = r_held;
        n_rep   = r_rep;
        n_press = r_press;
        n_last  = r_last;
        fire    = 1'b0;
        if (!i_down) begin
            n_held = 1'b0;
            n_rep  = 1'b0;
        end else if (!r_held) begin
            n_held  = 1'b1;
            n_press = i_now;
            n_rep   = 1'b0;
            fire    = 1'b1;
        end else if (!r_rep) begin
            if (press_age >= {16'd0, i_delay}) begin
                n_rep  = 1'b1;
                n_last = i_now;
                fire   = 1'b1;
            end
        end else if (last_age >= {16'd0, i_period}) begin
            n_last = i_now;
            fire   = 1'b1;
        end
    end

    assign o_status.fire       = fire;
    assign o_status.repeat_hit = r_held;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held  <= 1'b0;
            r_rep   <= 1'b0;
            r_press <= '0;
            r_last  <= '0;
        end else if (i_en) begin
            r_held  <= n_held;
            r_rep   <= n_rep;
            r_press <= n_press;
            r_last  <= n_last;
        end
    end

endmodule

// ----- rtl/core/khr_keymap.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// khr_keymap
// Decodes the valid key slots: arrow levels and the first non-arrow key,
// mapped to its event kind.
// ----------------------------------------------------------------------------
module khr_keymap #(
    parameter int MAX_KEYS = khr_pkg::MAX_KEYS_DEF
) (
    input  khr_pkg::t_in_item i_item,
    output khr_pkg::t_key_map o_map
);

    localparam int LIMIT = (MAX_KEYS < khr_pkg::NUM_SLOTS) ? MAX_KEYS : khr_pkg::NUM_SLOTS;

    logic [7:0] codes [khr_pkg::NUM_SLOTS];
    logic [2:0] count;
    logic [khr_pkg::NUM_SLOTS-1:0] slot_ok;
    logic [khr_pkg::NUM_SLOTS-1:0] slot_arrow;

    assign codes[0] = i_item.key_code_0;
    assign codes[1] = i_item.key_code_1;
    assign codes[2] = i_item.key_code_2;
    assign codes[3] = i_item.key_code_3;
    assign codes[4] = i_item.key_code_4;
    assign codes[5] = i_item.key_code_5;

    assign count = (i_item.key_count > 3'(LIMIT)) ? 3'(LIMIT) : i_item.key_count;

    always_comb begin
        o_map.arrow_now = '0;
        for (int i = 0; i < khr_pkg::NUM_SLOTS; i++) begin
            slot_ok[i]    = (3'(i) < count);
            slot_arrow[i] = 1'b1;
            case (codes[i])
                khr_pkg::KEY_UP:    o_map.arrow_now[khr_pkg::DIR_UP]    |= slot_ok[i];
                khr_pkg::KEY_DOWN:  o_map.arrow_now[khr_pkg::DIR_DOWN]  |= slot_ok[i];
                khr_pkg::KEY_LEFT:  o_map.arrow_now[khr_pkg::DIR_LEFT]  |= slot_ok[i];
                khr_pkg::KEY_RIGHT: o_map.arrow_now[khr_pkg::DIR_RIGHT] |= slot_ok[i];
                default:            slot_arrow[i] = 1'b0;
            endcase
        end

        // first usable slot wins, so scan from the back
        o_map.hit  = 1'b0;
        o_map.kind = khr_pkg::EV_CHAR;
        o_map.code = '0;
        for (int i = khr_pkg::NUM_SLOTS - 1; i >= 0; i--) begin
            if (slot_ok[i] && !slot_arrow[i]) begin
                o_map.hit  = 1'b1;
                o_map.code = codes[i];
                case (codes[i])
                    khr_pkg::KEY_HOME:   o_map.kind = khr_pkg::EV_HOME;
                    khr_pkg::KEY_TAB:    o_map.kind = khr_pkg::EV_TOGGLE;
                    khr_pkg::KEY_PWR_LO: o_map.kind = khr_pkg::EV_POWER;
                    khr_pkg::KEY_PWR_HI: o_map.kind = khr_pkg::EV_POWER;
                    khr_pkg::KEY_SETUP:  o_map.kind = khr_pkg::EV_SETUP;
                    khr_pkg::KEY_ESC:    o_map.kind = khr_pkg::EV_ESCAPE;
                    default:             o_map.kind = khr_pkg::EV_CHAR;
                endcase
            end
        end
    end

endmodule

// ----- rtl/core/key_hold_repeat_event_generator_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_hold_repeat_event_generator_unit
// Keyboard typematic event generator: one poll in, at most one event out.
// ----------------------------------------------------------------------------
// Takes one keyboard poll per clock cycle unless a waiting event stalls the
// input. A poll is registered on accept and resolved, once the output
// register is free or being taken, by the five hold trackers (enter, up, down,
// left, right) and the key slot decoder in one priority pass; its event, if
// any, is then written into the output register. Polls that cause no event
// produce no output item. The output register decouples the sides, so one
// more poll is taken while an event waits. The configuration port is always
// ready; write it only while no poll is in flight.
module key_hold_repeat_event_generator_unit #(
    parameter int MAX_KEYS = khr_pkg::MAX_KEYS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  khr_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output khr_pkg::t_out_item o_out_item,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [0:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data
);

    localparam int NT = khr_pkg::NUM_TRACK;

    logic [15:0]        r_delay_ms;
    logic [15:0]        r_period_ms;
    logic               r_in_valid;
    khr_pkg::t_in_item  r_in;
    logic               r_out_valid;
    khr_pkg::t_out_item r_out;
    khr_pkg::t_out_item n_out;
    logic               n_has;
    logic               proc_go;
    khr_pkg::t_key_map  key_map;
    khr_pkg::t_trk_status trk [NT];
    logic [NT-1:0]      trk_en;
    logic [NT-1:0]      trk_down;

    assign o_cfg_ready = 1'b1;
    assign proc_go     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || proc_go;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay_ms  <= khr_pkg::DELAY_RST;
            r_period_ms <= khr_pkg::PERIOD_RST;
        end else begin
            if (i_cfg_valid) begin
                unique case (khr_pkg::t_cfg_index'(i_cfg_index))
                    khr_pkg::CFG_DELAY:  r_delay_ms  <= i_cfg_data;
                    khr_pkg::CFG_PERIOD: r_period_ms <= i_cfg_data;
                    default:             r_delay_ms  <= r_delay_ms;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_valid <= 1'b1;
        end else if (proc_go) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_item;
        end
    end

    khr_keymap #(
        .MAX_KEYS (MAX_KEYS)
    ) u_keymap (
        .i_item (r_in),
        .o_map  (key_map)
    );

    assign trk_down = {key_map.arrow_now, r_in.enter_down};

    genvar t;
    generate
        for (t = 0; t < NT; t++) begin : g_trk
            if (t == 0) begin : g_first
                assign trk_en[t] = proc_go;
            end else begin : g_next
                assign trk_en[t] = trk_en[t-1] && !trk[t-1].fire;
            end
            khr_tracker u_trk (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_en     (trk_en[t]),
                .i_down   (trk_down[t]),
                .i_now    (r_in.now_ms),
                .i_delay  (r_delay_ms),
                .i_period (r_period_ms),
                .o_status (trk[t])
            );
        end
    endgenerate

    always_comb begin
        n_out = '0;
        n_has = 1'b0;
        if (trk[0].fire) begin
            n_has = 1'b1;
            n_out.event_kind = trk[0].repeat_hit ? khr_pkg::EV_REPEAT : khr_pkg::EV_CONFIRM;
        end else if (trk[1].fire) begin
            n_has = 1'b1;
            n_out.event_kind = khr_pkg::EV_NAV;
            n_out.nav_dir    = khr_pkg::DIR_UP;
        end else if (trk[2].fire) begin
            n_has = 1'b1;
            n_out.event_kind = khr_pkg::EV_NAV;
            n_out.nav_dir    = khr_pkg::DIR_DOWN;
        end else if (trk[3].fire) begin
            n_has = 1'b1;
            n_out.event_kind = khr_pkg::EV_NAV;
            n_out.nav_dir    = khr_pkg::DIR_LEFT;
        end else if (trk[4].fire) begin
            n_has = 1'b1;
            n_out.event_kind = khr_pkg::EV_NAV;
            n_out.nav_dir    = khr_pkg::DIR_RIGHT;
        end else if (r_in.keys_changed && r_in.any_pressed && key_map.hit) begin
            n_has = 1'b1;
            n_out.event_kind = key_map.kind;
            if (key_map.kind == khr_pkg::EV_CHAR) begin
                n_out.char_code = key_map.code;
                n_out.shift_out = r_in.shift_down;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc_go) begin
            r_out_valid <= n_has;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc_go) begin
            r_out <= n_out;
        end
    end

endmodule

// ----- rtl/core/khr_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// khr_checker
// Port-level checks of the key hold and auto-repeat event generator.
// ----------------------------------------------------------------------------
module khr_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input khr_pkg::t_out_item o_out_item
);

    // a stalled item holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("output item changed while stalled");

    a_rst_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output item right after reset");

    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_item.event_kind <= khr_pkg::EV_CHAR)
        else $error("event kind out of range");

    a_dir_nav: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.event_kind != khr_pkg::EV_NAV |-> o_out_item.nav_dir == 2'd0)
        else $error("direction on a non-nav item");

    a_char_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.event_kind != khr_pkg::EV_CHAR
            |-> o_out_item.char_code == 8'd0 && !o_out_item.shift_out)
        else $error("char payload on a non-char item");

endmodule

bind key_hold_repeat_event_generator_unit khr_checker u_khr_checker (.*);
